@@ hw/rtl/iomh_pkg.sv @@
// Shared types and constants for the instruction operand mode histogram.
// Holds the channel payload structs, the store geometry and the class codes.
// No dependencies.
`default_nettype none

package iomh_pkg;

  // Store geometry
  localparam int INSTR_KINDS  = 128;
  localparam int CLASS_COUNT  = 80;
  localparam int KIND_STRIDE  = CLASS_COUNT * CLASS_COUNT;
  localparam int STORE_DEPTH  = INSTR_KINDS * KIND_STRIDE;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W        = 32;
  localparam int CLASS_W      = 7;

  // Command codes
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Operand class codes
  localparam logic [CLASS_W-1:0] CLASS_NONE    = 7'd0;
  localparam logic [CLASS_W-1:0] CLASS_ERROR   = 7'd1;
  localparam logic [CLASS_W-1:0] CLASS_REG     = 7'd2;
  localparam logic [CLASS_W-1:0] CLASS_REG_REL = 7'd3;
  localparam logic [CLASS_W-1:0] CLASS_INDEXED = 7'd16;

  localparam logic [15:0] CODE_NONE = 16'hFFFF;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  instr_kind;
    logic [15:0] first_operand_code;
    logic [15:0] second_operand_code;
    logic [6:0]  read_class_first;
    logic [6:0]  read_class_second;
  } in_item_t;

  typedef struct packed {
    logic [31:0] counter_value;
    logic [6:0]  class_first;
    logic [6:0]  class_second;
    logic        accepted;
  } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/iomh_ram.sv @@
// Generic single-port RAM with registered read data.
// Width and depth are parameters; no package dependency.
`default_nettype none

module iomh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write, or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/iomh_classify.sv @@
// Operand addressing code classifier: maps a raw 16-bit code to one of
// 80 operand classes. Depends on iomh_pkg.
`default_nettype none

module iomh_classify (
  input  wire logic [15:0]                 code,
  output logic      [iomh_pkg::CLASS_W-1:0] op_class
);

  // Class of a 5-bit base value; indexed-within-indexed counts as error
  function automatic logic [iomh_pkg::CLASS_W-1:0] base_class(input logic [4:0] b);
    logic [iomh_pkg::CLASS_W-1:0] res;
    if (b <= 5'd7) begin
      res = iomh_pkg::CLASS_REG;
    end else if (b <= 5'd15) begin
      res = iomh_pkg::CLASS_REG_REL;
    end else if (b <= 5'd27) begin
      res = 7'({2'b00, b} - 7'd12);
    end else begin
      res = iomh_pkg::CLASS_ERROR;
    end
    return res;
  endfunction

  logic [7:0] low_byte;
  logic       is_simple;
  logic       is_indexed;

  assign low_byte   = code[7:0];
  assign is_simple  = (code[15:5] == 11'd0) && (code[4:0] <= 5'd27);
  assign is_indexed = (low_byte >= 8'd28) && (low_byte <= 8'd31);

  // Scale term: low byte 28..31 gives scale 0..3 from its two low bits
  always_comb begin
    priority if (code == iomh_pkg::CODE_NONE) begin
      op_class = iomh_pkg::CLASS_NONE;
    end else if (is_simple) begin
      op_class = base_class(code[4:0]);
    end else if (is_indexed) begin
      op_class = iomh_pkg::CLASS_INDEXED + {1'b0, low_byte[1:0], 4'd0}
                 + base_class(code[15:11]);
    end else begin
      op_class = iomh_pkg::CLASS_ERROR;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/instruction_operand_mode_histogram.sv @@
// Top level of the instruction operand mode histogram.
// Depends on iomh_pkg, iomh_classify and iomh_ram.
//
// Profiling counter store: a count transfer classifies both operand codes
// and bumps the saturating 32-bit counter for (kind, class0, class1); a
// read transfer returns one counter unchanged. Every input transfer gives
// exactly one result (a zero counter if kind or read class is out of range).
// After reset the block sweeps the whole counter memory to zero, one entry
// per cycle, with in_stall held high. After that, the result is loaded
// into the output register after the input transfer (address, memory read,
// increment and write-back through the single memory port; both operand
// codes are classified as they arrive). The next item can be taken in the
// cycle after the result is loaded, even while that result is still stalled.
// A result still stalled when the next item reaches write-back holds it there.
`default_nettype none

module instruction_operand_mode_histogram (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire iomh_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output iomh_pkg::out_item_t     out_data
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  localparam int AW = iomh_pkg::ADDR_W;
  localparam int CW = iomh_pkg::CLASS_W;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]       addr_r;
  logic                cmd_r;
  logic                ok_r;
  logic [7:0]          kind_r;
  logic [CW-1:0]       cls0_r, cls1_r;
  logic                out_valid_r, out_valid_nxt;
  iomh_pkg::out_item_t out_data_r;

  logic [CW-1:0]       code_cls0, code_cls1;
  logic [CW-1:0]       sel_cls0, sel_cls1;
  logic                in_xfer, out_xfer, upd_go;
  logic                kind_ok, cls_ok;
  logic [AW-1:0]       addr_calc;

  logic                ram_en, ram_we;
  logic [AW-1:0]       ram_addr;
  logic [31:0]         ram_wdata, ram_rdata;
  logic [31:0]         cnt_next;

  // Operand classifiers
  iomh_classify u_cls0 (.code(in_data.first_operand_code),  .op_class(code_cls0));
  iomh_classify u_cls1 (.code(in_data.second_operand_code), .op_class(code_cls1));

  // Counter store
  iomh_ram #(
    .WIDTH(iomh_pkg::CNT_W),
    .DEPTH(iomh_pkg::STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Handshakes
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_xfer  = out_valid_r && !out_stall;
  assign upd_go    = (state_r == ST_UPD) && !(out_valid_r && out_stall);

  // Class selection and range check at the input transfer
  assign sel_cls0 = (in_data.cmd == iomh_pkg::CMD_COUNT) ? code_cls0 : in_data.read_class_first;
  assign sel_cls1 = (in_data.cmd == iomh_pkg::CMD_COUNT) ? code_cls1 : in_data.read_class_second;
  assign kind_ok  = {1'b0, in_data.instr_kind} < 9'(iomh_pkg::INSTR_KINDS);
  assign cls_ok   = (in_data.cmd == iomh_pkg::CMD_COUNT) ||
                    ((8'(in_data.read_class_first)  < 8'(iomh_pkg::CLASS_COUNT)) &&
                     (8'(in_data.read_class_second) < 8'(iomh_pkg::CLASS_COUNT)));

  // Flat counter address: kind * 6400 + class0 * 80 + class1 (constant multiplies)
  assign addr_calc = AW'(AW'(kind_r) * AW'(iomh_pkg::KIND_STRIDE))
                   + AW'(AW'(cls0_r) * AW'(iomh_pkg::CLASS_COUNT))
                   + AW'(cls1_r);

  // Saturating increment
  assign cnt_next = (ram_rdata == 32'hFFFF_FFFF) ? ram_rdata : ram_rdata + 32'd1;

  // Memory port sharing: clearing sweep, read, write-back
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_r;
    ram_wdata = cnt_next;
    unique case (state_r)
      ST_CLR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = '0;
      end
      ST_READ: begin
        ram_en = ok_r;
      end
      ST_UPD: begin
        ram_en = upd_go && ok_r && (cmd_r == iomh_pkg::CMD_COUNT);
        ram_we = 1'b1;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(iomh_pkg::STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_UPD;
      ST_UPD: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  // Output valid: set when a result loads, cleared on its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    if (upd_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r  <= in_data.cmd;
      kind_r <= in_data.instr_kind;
      cls0_r <= sel_cls0;
      cls1_r <= sel_cls1;
      ok_r   <= kind_ok && cls_ok;
    end
    if (state_r == ST_ADDR) begin
      addr_r <= addr_calc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_data_r.class_first  <= cls0_r;
      out_data_r.class_second <= cls1_r;
      out_data_r.accepted     <= ok_r;
      if (!ok_r) begin
        out_data_r.counter_value <= '0;
      end else if (cmd_r == iomh_pkg::CMD_COUNT) begin
        out_data_r.counter_value <= cnt_next;
      end else begin
        out_data_r.counter_value <= ram_rdata;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/iomh_checker.sv @@
// Port-level checker for the instruction operand mode histogram, bound to
// the top level. Depends on iomh_pkg.
`default_nettype none

module iomh_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire iomh_pkg::out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A taken item keeps the input stalled while it is worked on
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // Rejected access reports a zero counter
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> out_data.counter_value == 32'd0)
    else $error("rejected access with nonzero counter");

  // Accepted results always name classes within the table
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |->
      (out_data.class_first < 7'(iomh_pkg::CLASS_COUNT)) &&
      (out_data.class_second < 7'(iomh_pkg::CLASS_COUNT)))
    else $error("accepted result with class out of range");

endmodule

bind instruction_operand_mode_histogram iomh_checker u_iomh_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire
